/* hdl/ktarp_pkg.sv */
package ktarp_pkg;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int ROUND_W = 3;
  localparam int BYTE_W  = 8;
  localparam int BLOCK_W = 64;
  localparam int ADDR_W  = ROUND_W + BYTE_W;
  localparam int TABLE_DEPTH = 2048;

  // Rotation amount per round
  localparam int ROT_BITS = 8;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_FWD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_INV = 2'd1;
  localparam logic [KIND_W-1:0] KIND_XF_FWD   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_XF_INV   = 2'd3;

  // Round bounds
  localparam logic [ROUND_W-1:0] ROUND_FIRST = 3'd0;
  localparam logic [ROUND_W-1:0] ROUND_LAST  = 3'd7;

  // Classified request passed from front to back
  typedef struct packed {
    logic                is_load;
    logic                inv;
    logic [ADDR_W-1:0]   addr;
    logic [BLOCK_W-1:0]  value;
  } req_t;

  function automatic logic [BLOCK_W-1:0] rotl8(input logic [BLOCK_W-1:0] v);
    rotl8 = {v[BLOCK_W-ROT_BITS-1:0], v[BLOCK_W-1:BLOCK_W-ROT_BITS]};
  endfunction

  function automatic logic [BLOCK_W-1:0] rotr8(input logic [BLOCK_W-1:0] v);
    rotr8 = {v[ROT_BITS-1:0], v[BLOCK_W-1:ROT_BITS]};
  endfunction

endpackage

/* hdl/ktarp_ram.sv */
module ktarp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/ktarp_front.sv */
module ktarp_front #(
  parameter int DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ktarp_pkg::KIND_W-1:0]  in_kind,
  input  logic [ktarp_pkg::ROUND_W-1:0] in_round_sel,
  input  logic [ktarp_pkg::BYTE_W-1:0]  in_byte_sel,
  input  logic [ktarp_pkg::BLOCK_W-1:0] in_value,
  output logic                          q_valid,
  output ktarp_pkg::req_t               q_req,
  input  logic                          q_pop
);
  import ktarp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  req_t             mem [DEPTH];
  req_t             req_in;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;

  // Classify the incoming request
  always_comb begin
    req_in.is_load = (in_kind == KIND_LOAD_FWD) || (in_kind == KIND_LOAD_INV);
    req_in.inv     = (in_kind == KIND_LOAD_INV) || (in_kind == KIND_XF_INV);
    req_in.addr    = {in_round_sel, in_byte_sel};
    req_in.value   = in_value;
  end

  assign busy    = (count_r == CNT_FULL);
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign q_req   = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= req_in;
    end
  end

endmodule

/* hdl/ktarp_engine.sv */
module ktarp_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  ktarp_pkg::req_t               q_req,
  output logic                          q_pop,
  output logic                          out_strobe,
  output logic [ktarp_pkg::BLOCK_W-1:0] out_block_out
);
  import ktarp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic               state_r, state_nxt;
  logic [ROUND_W-1:0] rnd_r, rnd_nxt;
  logic               inv_r, inv_nxt;
  logic [BLOCK_W-1:0] blk_r, blk_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic [BLOCK_W-1:0] out_block_r, out_block_nxt;

  logic               start_xf, calc, last;
  logic               fwd_wr, inv_wr, rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [BLOCK_W-1:0] fwd_rd, inv_rd, entry;
  logic [BLOCK_W-1:0] blk_in, sum, diff, fwd_next, inv_next, blk_step;
  logic [ROUND_W-1:0] rnd_first, rnd_step;

  // Pop and dispatch
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign start_xf = q_pop && !q_req.is_load;
  assign fwd_wr   = q_pop && q_req.is_load && !q_req.inv;
  assign inv_wr   = q_pop && q_req.is_load && q_req.inv;
  assign calc     = (state_r == ST_CALC);

  // First round: inverse rotates before its lookup
  assign blk_in    = q_req.inv ? rotr8(q_req.value) : q_req.value;
  assign rnd_first = q_req.inv ? ROUND_LAST : ROUND_FIRST;

  // Round datapath
  assign entry    = inv_r ? inv_rd : fwd_rd;
  assign sum      = blk_r + entry;
  assign diff     = blk_r - entry;
  assign fwd_next = rotl8(sum);
  assign inv_next = rotr8(diff);
  assign blk_step = inv_r ? inv_next : fwd_next;
  assign last     = inv_r ? (rnd_r == ROUND_FIRST) : (rnd_r == ROUND_LAST);
  assign rnd_step = inv_r ? rnd_r - 1'b1 : rnd_r + 1'b1;

  // Next lookup address
  assign rd_en   = start_xf || (calc && !last);
  assign rd_addr = calc ? {rnd_step, blk_step[BYTE_W-1:0]} : {rnd_first, blk_in[BYTE_W-1:0]};

  always_comb begin
    state_nxt      = state_r;
    rnd_nxt        = rnd_r;
    inv_nxt        = inv_r;
    blk_nxt        = blk_r;
    out_strobe_nxt = 1'b0;
    out_block_nxt  = out_block_r;
    case (state_r)
      ST_IDLE: begin
        if (start_xf) begin
          state_nxt = ST_CALC;
          rnd_nxt   = rnd_first;
          inv_nxt   = q_req.inv;
          blk_nxt   = blk_in;
        end
      end
      ST_CALC: begin
        blk_nxt = blk_step;
        rnd_nxt = rnd_step;
        if (last) begin
          state_nxt      = ST_IDLE;
          out_strobe_nxt = 1'b1;
          out_block_nxt  = inv_r ? diff : fwd_next;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r       <= rnd_nxt;
    inv_r       <= inv_nxt;
    blk_r       <= blk_nxt;
    out_block_r <= out_block_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_block_out = out_block_r;

  // Forward and inverse round tables
  ktarp_ram #(
    .WIDTH(BLOCK_W),
    .DEPTH(TABLE_DEPTH)
  ) u_fwd_ram (
    .clk    (clk),
    .wr_en  (fwd_wr),
    .wr_addr(q_req.addr),
    .wr_data(q_req.value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(fwd_rd)
  );

  ktarp_ram #(
    .WIDTH(BLOCK_W),
    .DEPTH(TABLE_DEPTH)
  ) u_inv_ram (
    .clk    (clk),
    .wr_en  (inv_wr),
    .wr_addr(q_req.addr),
    .wr_data(q_req.value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(inv_rd)
  );

endmodule

/* hdl/keyed_table_add_rotate_permutation_core.sv */
// Transforms run 8 table rounds on each table's single read port, after dispatch; the engine pops no
//   new request until the current transform ends, and a load is written when it is popped.
//   A request queue of QUEUE_DEPTH entries takes requests while the engine works; busy is high
//   only while that queue is full. Results cannot be held off.
// Reset: synchronous, active low; clears the queue and the engine. The round tables are not
//   cleared and read as undefined until written.
module keyed_table_add_rotate_permutation_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ktarp_pkg::KIND_W-1:0]  in_kind,
  input  logic [ktarp_pkg::ROUND_W-1:0] in_round_sel,
  input  logic [ktarp_pkg::BYTE_W-1:0]  in_byte_sel,
  input  logic [ktarp_pkg::BLOCK_W-1:0] in_value,
  output logic                          out_strobe,
  output logic [ktarp_pkg::BLOCK_W-1:0] out_block_out
);
  import ktarp_pkg::*;

  req_t q_req;
  logic q_valid;
  logic q_pop;

  // Accept and classify requests
  ktarp_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_round_sel(in_round_sel),
    .in_byte_sel (in_byte_sel),
    .in_value    (in_value),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop)
  );

  // Table writes and round iteration
  ktarp_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_pop        (q_pop),
    .out_strobe   (out_strobe),
    .out_block_out(out_block_out)
  );

endmodule

/* hdl/ktarp_checker.sv */
module ktarp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [ktarp_pkg::BLOCK_W-1:0] out_block_out
);

  // Reset leaves the block empty and silent
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_strobe && !busy))
    else $error("strobe or busy after reset");

  // The queue only fills on an accepted request
  a_busy_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // A transform takes several rounds, so results never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results on consecutive cycles");

  // The engine runs every round of a transform before the next, so results are at least one transform time apart
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe [*8])
    else $error("results closer than one transform time");

endmodule

bind keyed_table_add_rotate_permutation_core ktarp_checker u_ktarp_checker (.*);
